### sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam logic [2:0] MODE_PUTC  = 3'd0;
    localparam logic [2:0] MODE_KEY   = 3'd1;
    localparam logic [2:0] MODE_CLEAR = 3'd2;
    localparam logic [2:0] MODE_SET   = 3'd3;
    localparam logic [2:0] MODE_RIGHT = 3'd4;
    localparam logic [2:0] MODE_LEFT  = 3'd5;
    localparam logic [2:0] MODE_READ  = 3'd6;

    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_BLANK = 8'h20;
    localparam logic [7:0] CHAR_FILL  = 8'h00;

    localparam logic [7:0] ATTR0_RST = 8'h30;
    localparam logic [7:0] ATTR1_RST = 8'h40;
    localparam logic [7:0] ATTR2_RST = 8'h50;

    localparam logic [1:0] REG_ATTR0 = 2'd0;
    localparam logic [1:0] REG_ATTR1 = 2'd1;
    localparam logic [1:0] REG_ATTR2 = 2'd2;

    // Command handed from the front end to the back end.
    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] terminal;
        logic [7:0] char_code;
        logic [6:0] pos_x;
        logic [4:0] pos_y;
        logic       bad_term;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_READ,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_CLEAR,
        ST_DONE
    } t_state;

endpackage

### sv/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Accepts commands, classifies the terminal and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tcw_front
    import tcw_pkg::*;
#(
    parameter int TERMINAL_COUNT = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [2:0] i_mode,
    input  logic [1:0] i_terminal,
    input  logic [7:0] i_char_code,
    input  logic [6:0] i_pos_x,
    input  logic [4:0] i_pos_y,
    output logic       o_full,
    output logic       o_valid,
    output t_cmd       o_cmd,
    input  logic       i_pop
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;

    always_comb begin
        n_cmd.mode      = i_mode;
        n_cmd.terminal  = i_terminal;
        n_cmd.char_code = i_char_code;
        n_cmd.pos_x     = i_pos_x;
        n_cmd.pos_y     = i_pos_y;
        n_cmd.bad_term  = ({2'b00, i_terminal} >= 4'(TERMINAL_COUNT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_q[r_wp] <= n_cmd;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];

endmodule

### sv/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Carries out commands: cursor updates, cell writes, scroll, clear and reads.
// ----------------------------------------------------------------------------
module tcw_back
    import tcw_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25,
    parameter int TERMINAL_COUNT = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    input  logic [7:0] i_attr0,
    input  logic [7:0] i_attr1,
    input  logic [7:0] i_attr2,
    output logic       o_wiping,
    output logic       o_strobe,
    output logic [6:0] o_cursor_x,
    output logic [4:0] o_cursor_y,
    output logic [10:0] o_cursor_position,
    output logic [7:0] o_cell_char,
    output logic [7:0] o_cell_attr
);

    localparam int PAGE  = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int DEPTH = PAGE * TERMINAL_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = (TERMINAL_COUNT > 1) ? $clog2(TERMINAL_COUNT) : 1;
    localparam int PW    = $clog2(PAGE + 1);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmdr;
    logic [6:0] r_col [TERMINAL_COUNT];
    logic [4:0] r_row [TERMINAL_COUNT];
    logic [AW-1:0] r_addr, n_addr;
    logic [PW-1:0] r_cnt, n_cnt;
    logic          r_rdok, n_rdok;
    logic          r_strobe, n_strobe;
    logic [6:0] r_ox, n_ox;
    logic [4:0] r_oy, n_oy;
    logic [10:0] r_op, n_op;
    logic [7:0] r_oc, n_oc;
    logic [7:0] r_oa, n_oa;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0] wdata;
    logic        cwe;
    logic [6:0]  ccol;
    logic [4:0]  crow;

    logic [TW-1:0] ctix;
    logic [6:0]    col;
    logic [4:0]    row;
    logic [7:0]    attr;
    logic [AW-1:0] base;

    assign ctix = TW'(r_cmd.terminal);

    always_comb begin
        case (r_cmd.terminal)
            2'd0:    attr = i_attr0;
            2'd1:    attr = i_attr1;
            2'd2:    attr = i_attr2;
            default: attr = 8'h00;
        endcase
    end

    // Page base by repeated add is avoided: the terminal count is small.
    always_comb begin
        base = '0;
        for (int k = 0; k < TERMINAL_COUNT; k++)
            if (32'(k) == 32'(r_cmd.terminal)) base = AW'(k * PAGE);
    end

    assign col = r_col[ctix];
    assign row = r_row[ctix];

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_WIPE;
            r_strobe <= 1'b0;
            r_addr   <= '0;
            for (int k = 0; k < TERMINAL_COUNT; k++) begin
                r_col[k] <= '0;
                r_row[k] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_addr   <= n_addr;
            if (cwe) begin
                r_col[ctix] <= ccol;
                r_row[ctix] <= crow;
            end
        end
        r_cmd  <= n_cmdr;
        r_cnt  <= n_cnt;
        r_rdok <= n_rdok;
        r_ox <= n_ox; r_oy <= n_oy; r_op <= n_op; r_oc <= n_oc; r_oa <= n_oa;
    end

    logic [AW-1:0] cell_a;
    logic [6:0]    nc;
    logic [4:0]    nr;

    always_comb begin
        n_state = r_state; n_cmdr = r_cmd; n_addr = r_addr; n_cnt = r_cnt;
        n_rdok = r_rdok; n_strobe = 1'b0;
        n_ox = r_ox; n_oy = r_oy; n_op = r_op; n_oc = r_oc; n_oa = r_oa;
        o_pop = 1'b0; we = 1'b0; waddr = r_addr; wdata = '0; raddr = r_addr;
        cwe = 1'b0; ccol = col; crow = row;
        nc = col; nr = row;
        cell_a = AW'(base + AW'(32'(row) * SCREEN_COLUMNS) + AW'(col));
        unique case (r_state)
            ST_WIPE: begin
                we = 1'b1; wdata = '0;
                n_addr = r_addr + 1'b1;
                if (32'(r_addr) == DEPTH - 1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1; n_cmdr = i_cmd;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                // Execute the command; the cursor is that of r_cmd's terminal.
                n_oc = '0; n_oa = '0;
                n_state = ST_DONE;
                if (r_cmd.bad_term) begin
                    n_ox = '0; n_oy = '0; n_op = '0;
                    n_strobe = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    unique case (r_cmd.mode)
                        MODE_PUTC, MODE_KEY: begin
                            if (r_cmd.char_code == CHAR_LF ||
                                r_cmd.char_code == CHAR_CR) begin
                                nc = '0; nr = row + 1'b1;
                            end else if (r_cmd.mode == MODE_KEY &&
                                         r_cmd.char_code == CHAR_BS) begin
                                if (col != '0) begin
                                    nc = col - 1'b1;
                                end else if (row != '0) begin
                                    nc = 7'(SCREEN_COLUMNS - 1); nr = row - 1'b1;
                                end
                                we = 1'b1;
                                waddr = AW'(base + AW'(32'(nr) * SCREEN_COLUMNS) + AW'(nc));
                                wdata = {attr, CHAR_BLANK};
                            end else begin
                                we = 1'b1; waddr = cell_a;
                                wdata = {attr, r_cmd.char_code};
                                if (32'(col) == SCREEN_COLUMNS - 1) begin
                                    nc = '0; nr = row + 1'b1;
                                end else begin
                                    nc = col + 1'b1;
                                end
                            end
                            if (32'(nr) >= SCREEN_ROWS) begin
                                nc = '0; nr = 5'(SCREEN_ROWS - 1);
                                n_addr = base;
                                n_cnt = '0;
                                n_state = ST_SCROLL_RD;
                            end
                        end
                        MODE_CLEAR: begin
                            nc = '0; nr = '0;
                            n_addr = base; n_cnt = '0;
                            n_state = ST_CLEAR;
                        end
                        MODE_SET: begin
                            nc = (32'(r_cmd.pos_x) < SCREEN_COLUMNS) ? r_cmd.pos_x
                                 : 7'(SCREEN_COLUMNS - 1);
                            nr = (32'(r_cmd.pos_y) < SCREEN_ROWS) ? r_cmd.pos_y
                                 : 5'(SCREEN_ROWS - 1);
                        end
                        MODE_RIGHT: begin
                            if (32'(col) < SCREEN_COLUMNS - 1) nc = col + 1'b1;
                            else if (32'(row) < SCREEN_ROWS - 1) begin
                                nc = '0; nr = row + 1'b1;
                            end
                        end
                        MODE_LEFT: begin
                            if (col != '0) nc = col - 1'b1;
                            else if (row != '0) begin
                                nc = 7'(SCREEN_COLUMNS - 1); nr = row - 1'b1;
                            end
                        end
                        MODE_READ: begin
                            n_rdok = (32'(r_cmd.pos_x) < SCREEN_COLUMNS) &&
                                     (32'(r_cmd.pos_y) < SCREEN_ROWS);
                            raddr = AW'(base + AW'(32'(r_cmd.pos_y) * SCREEN_COLUMNS)
                                    + AW'(r_cmd.pos_x));
                        end
                        default: ;
                    endcase
                    cwe = 1'b1; ccol = nc; crow = nr;
                    n_ox = nc; n_oy = nr;
                    n_op = 11'(32'(nc) + 32'(nr) * SCREEN_COLUMNS);
                end
            end
            ST_SCROLL_RD: begin
                // Read the cell one row below; the write follows next cycle.
                raddr = AW'(r_addr + AW'(SCREEN_COLUMNS));
                n_state = ST_SCROLL_WR;
            end
            ST_SCROLL_WR: begin
                we = 1'b1;
                wdata = (32'(r_cnt) < PAGE - SCREEN_COLUMNS) ? r_rdata
                        : {attr, CHAR_FILL};
                n_addr = r_addr + 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (32'(r_cnt) == PAGE - 1) n_state = ST_DONE;
                else if (32'(r_cnt) + 1 < PAGE - SCREEN_COLUMNS) n_state = ST_SCROLL_RD;
            end
            ST_CLEAR: begin
                we = 1'b1; wdata = {attr, CHAR_BLANK};
                n_addr = r_addr + 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (32'(r_cnt) == PAGE - 1) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (r_cmd.mode == MODE_READ && r_rdok) begin
                    n_oc = r_rdata[7:0]; n_oa = r_rdata[15:8];
                end
                n_strobe = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_wiping = (r_state == ST_WIPE);
    assign o_strobe = r_strobe;
    assign o_cursor_x = r_ox;
    assign o_cursor_y = r_oy;
    assign o_cursor_position = r_op;
    assign o_cell_char = r_oc;
    assign o_cell_attr = r_oa;

endmodule

### sv/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Multi-terminal text console: cursor control and screen cell store.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. The front end
// queues up to two commands; busy rises while the queue is full or while the
// cell store is being wiped after reset.
// Each command yields one result, shown for one cycle with o_valid; the
// receiver cannot stall and none is needed.
// From acceptance a command passes the queue and then ST_IDLE, ST_READ and
// ST_DONE of the back end, with any scroll or clear between the last two; a
// command naming a terminal out of range gives its result from ST_READ. The
// back end takes a new command only once back in ST_IDLE, so with the queue
// full a new beat waits for a pop. A scroll copies one page through the cell
// store: ST_SCROLL_RD then ST_SCROLL_WR per cell of the moved rows and
// ST_SCROLL_WR alone for the bottom row; a clear writes one cell a cycle.
// After reset the whole cell store (terminals x rows x columns entries) is
// zeroed one entry a cycle; commands wait, configuration writes are taken.
// Attribute registers are written through the cfg channel, always ready.
// ----------------------------------------------------------------------------
module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25,
    parameter int TERMINAL_COUNT = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [1:0]  i_terminal,
    input  logic [7:0]  i_char_code,
    input  logic [6:0]  i_pos_x,
    input  logic [4:0]  i_pos_y,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_valid,
    output logic [6:0]  o_cursor_x,
    output logic [4:0]  o_cursor_y,
    output logic [10:0] o_cursor_position,
    output logic [7:0]  o_cell_char,
    output logic [7:0]  o_cell_attr
);

    logic [7:0] r_attr0, r_attr1, r_attr2;
    logic full, qvalid, pop, wiping;
    t_cmd cmd;

    assign o_cfg_ready = 1'b1;
    assign busy = full | wiping;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr0 <= ATTR0_RST;
            r_attr1 <= ATTR1_RST;
            r_attr2 <= ATTR2_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ATTR0: r_attr0 <= i_cfg_data;
                REG_ATTR1: r_attr1 <= i_cfg_data;
                REG_ATTR2: r_attr2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tcw_front #(.TERMINAL_COUNT(TERMINAL_COUNT)) u_front (
        .i_clk, .i_rst_n,
        .i_push(start & ~busy),
        .i_mode, .i_terminal, .i_char_code, .i_pos_x, .i_pos_y,
        .o_full(full), .o_valid(qvalid), .o_cmd(cmd), .i_pop(pop)
    );

    tcw_back #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS), .SCREEN_ROWS(SCREEN_ROWS),
        .TERMINAL_COUNT(TERMINAL_COUNT)
    ) u_back (
        .i_clk, .i_rst_n,
        .i_valid(qvalid), .i_cmd(cmd), .o_pop(pop),
        .i_attr0(r_attr0), .i_attr1(r_attr1), .i_attr2(r_attr2),
        .o_wiping(wiping), .o_strobe(o_valid),
        .o_cursor_x, .o_cursor_y, .o_cursor_position,
        .o_cell_char, .o_cell_attr
    );

endmodule

### sv/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer.
// ----------------------------------------------------------------------------
module tcw_checker #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_valid,
    input logic [6:0]  o_cursor_x,
    input logic [4:0]  o_cursor_y,
    input logic [10:0] o_cursor_position
);

    a_busy_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy) else $error("busy low after reset");

    a_no_result_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result during reset");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 32'(o_cursor_position) < SCREEN_COLUMNS * SCREEN_ROWS)
        else $error("cursor out of page");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 32'(o_cursor_y) < SCREEN_ROWS && 32'(o_cursor_x) < SCREEN_COLUMNS)
        else $error("cursor field out of range");

endmodule

bind text_console_writer_unit tcw_checker #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS), .SCREEN_ROWS(SCREEN_ROWS)
) u_tcw_checker (
    .i_clk, .i_rst_n, .busy, .o_valid,
    .o_cursor_x, .o_cursor_y, .o_cursor_position
);
